>>> hdl/tppa_pkg.sv
// ----------------------------------------------------------------------------
// tppa_pkg
// shared types, register codes and layout constants for the tiled pattern
// pixel address unit
// ----------------------------------------------------------------------------
package tppa_pkg;

    // coordinate width default
    localparam int DEF_COORD_BITS = 12;

    // result widths
    localparam int OFFSET_BITS = 26;
    localparam int COLOR_BITS  = 32;

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_LAYOUT_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_KIND  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_STRIDE    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FORE_COLOR    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BACK_COLOR    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIPE_ENABLE = 3'd7;

    // layout codes, code three behaves as linear
    localparam logic [1:0] LAYOUT_LINEAR = 2'd0;
    localparam logic [1:0] LAYOUT_YTILED = 2'd1;
    localparam logic [1:0] LAYOUT_AFBC   = 2'd2;

    // pattern codes
    localparam logic PATTERN_CHECKER = 1'b0;
    localparam logic PATTERN_BORDER  = 1'b1;

    // checkerboard square size
    localparam int STRIPE_PIXELS = 37;

    typedef struct packed {
        logic [1:0]            layout_mode;
        logic                  pattern_kind;
        logic [12:0]           image_width;
        logic [12:0]           image_height;
        logic [13:0]           row_stride;
        logic [COLOR_BITS-1:0] fore_color;
        logic [COLOR_BITS-1:0] back_color;
        logic                  stripe_enable;
    } t_cfg;

    // placement of 4x4 subtiles inside a 16x16 block, indexed by column then row
    function automatic logic [3:0] af_subtile(input logic [1:0] sx, input logic [1:0] sy);
        logic [3:0] idx;
        idx = {sx, sy};
        case (idx)
            4'h0:    af_subtile = 4'd2;
            4'h1:    af_subtile = 4'd1;
            4'h2:    af_subtile = 4'd14;
            4'h3:    af_subtile = 4'd13;
            4'h4:    af_subtile = 4'd3;
            4'h5:    af_subtile = 4'd0;
            4'h6:    af_subtile = 4'd15;
            4'h7:    af_subtile = 4'd12;
            4'h8:    af_subtile = 4'd4;
            4'h9:    af_subtile = 4'd7;
            4'hA:    af_subtile = 4'd8;
            4'hB:    af_subtile = 4'd11;
            4'hC:    af_subtile = 4'd5;
            4'hD:    af_subtile = 4'd6;
            4'hE:    af_subtile = 4'd9;
            default: af_subtile = 4'd10;
        endcase
    endfunction

endpackage

>>> hdl/tppa_addr.sv
// ----------------------------------------------------------------------------
// tppa_addr
// three-stage word offset pipeline for linear, y-tiled and afbc layouts
// ----------------------------------------------------------------------------
module tppa_addr #(
    parameter int COORD_BITS = tppa_pkg::DEF_COORD_BITS
) (
    input  logic                             i_clk,
    input  tppa_pkg::t_cfg                   i_cfg,
    input  logic [COORD_BITS-1:0]            i_pixel_x,
    input  logic [COORD_BITS-1:0]            i_pixel_y,
    output logic [tppa_pkg::OFFSET_BITS-1:0] o_word_offset
);

    localparam int OW = tppa_pkg::OFFSET_BITS;

    // stage 1: products
    logic [9:0]    n_tiles_row;
    logic [9:0]    n_tiles_w;
    logic [9:0]    n_tiles_h;
    logic [OW-1:0] r1_lin_prod;
    logic [OW-1:0] r1_yt_prod;
    logic [OW-1:0] r1_af_prod;
    logic [18:0]   r1_af_cnt;
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;

    assign n_tiles_row = 10'((15'(i_cfg.row_stride) + 15'd31) >> 5);
    assign n_tiles_w   = 10'((14'(i_cfg.image_width) + 14'd15) >> 4);
    assign n_tiles_h   = 10'((14'(i_cfg.image_height) + 14'd15) >> 4);

    always_ff @(posedge i_clk) begin
        r1_lin_prod <= OW'(i_pixel_y) * OW'(i_cfg.row_stride);
        r1_yt_prod  <= OW'(i_pixel_y >> 5) * OW'(n_tiles_row);
        r1_af_prod  <= OW'(i_pixel_y >> 4) * OW'(n_tiles_w);
        r1_af_cnt   <= 19'(n_tiles_w) * 19'(n_tiles_h);
        r1_x        <= i_pixel_x;
        r1_y        <= i_pixel_y;
    end

    // stage 2: tile index adds and header rounding
    logic [OW-1:0] x1w;
    logic [OW-1:0] y1w;
    logic [OW-1:0] n_yt_tile;
    logic [OW-1:0] n_af_tile;
    logic [OW-1:0] r2_lin;
    logic [OW-1:0] r2_yt;
    logic [17:0]   r2_af_tile;
    logic [13:0]   r2_af_base;
    logic [7:0]    r2_af_low;

    assign x1w       = OW'(r1_x);
    assign y1w       = OW'(r1_y);
    assign n_yt_tile = r1_yt_prod + (x1w >> 5);
    assign n_af_tile = r1_af_prod + (x1w >> 4);

    always_ff @(posedge i_clk) begin
        r2_lin     <= r1_lin_prod + x1w;
        // column, row in tile and pixel in column fill the low ten bits
        r2_yt      <= {n_yt_tile[15:0], x1w[4:2], y1w[4:0], x1w[1:0]};
        r2_af_tile <= n_af_tile[17:0];
        // header is 16 bytes per block, padded to 1024 bytes = 256 words
        r2_af_base <= 14'((20'(r1_af_cnt) + 20'd63) >> 6);
        r2_af_low  <= {tppa_pkg::af_subtile(x1w[3:2], y1w[3:2]), y1w[1:0], x1w[1:0]};
    end

    // stage 3: body offset and layout select
    logic [OW-1:0] n_af;
    logic [OW-1:0] n_offset;
    logic [OW-1:0] r3_offset;

    assign n_af = OW'({r2_af_base, 8'd0}) + {r2_af_tile, r2_af_low};

    always_comb begin
        case (i_cfg.layout_mode)
            tppa_pkg::LAYOUT_YTILED: n_offset = r2_yt;
            tppa_pkg::LAYOUT_AFBC:   n_offset = n_af;
            default:                 n_offset = r2_lin;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_offset <= n_offset;
    end

    assign o_word_offset = r3_offset;

endmodule

>>> hdl/tppa_pattern.sv
// ----------------------------------------------------------------------------
// tppa_pattern
// two-stage pattern hit test: checkerboard parity by reciprocal multiply,
// or one-pixel border
// ----------------------------------------------------------------------------
module tppa_pattern #(
    parameter int COORD_BITS = tppa_pkg::DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  tppa_pkg::t_cfg        i_cfg,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output logic                  o_hit
);

    // floor(2^K / 37) underestimates x/37 by less than one
    localparam int K     = COORD_BITS + 6;
    localparam int RECIP = (2 ** K) / tppa_pkg::STRIPE_PIXELS;
    localparam int RW    = COORD_BITS + 1;
    localparam int PW    = COORD_BITS + RW;
    localparam int EW    = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [6:0]    STRIPE_C = 7'(tppa_pkg::STRIPE_PIXELS);

    // stage 1: reciprocal products
    logic [PW-1:0]         r1_xq;
    logic [PW-1:0]         r1_yq;
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;

    always_ff @(posedge i_clk) begin
        r1_xq <= PW'(i_pixel_x) * PW'(RECIP_C);
        r1_yq <= PW'(i_pixel_y) * PW'(RECIP_C);
        r1_x  <= i_pixel_x;
        r1_y  <= i_pixel_y;
    end

    // stage 2: quotient correction and hit
    logic [6:0] qx;
    logic [6:0] qy;
    logic [6:0] rem_x;
    logic [6:0] rem_y;
    logic       par_x;
    logic       par_y;
    logic       border;
    logic       n_hit;
    logic       r2_hit;

    // remainder stays below 74, so seven bits carry it exactly
    assign qx    = 7'(r1_xq >> K);
    assign qy    = 7'(r1_yq >> K);
    assign rem_x = 7'(r1_x) - qx * STRIPE_C;
    assign rem_y = 7'(r1_y) - qy * STRIPE_C;
    assign par_x = qx[0] ^ (rem_x >= STRIPE_C);
    assign par_y = qy[0] ^ (rem_y >= STRIPE_C);

    assign border = (r1_x == '0) || (r1_y == '0)
                 || ((EW'(r1_x) + EW'(1)) == EW'(i_cfg.image_width))
                 || ((EW'(r1_y) + EW'(1)) == EW'(i_cfg.image_height));

    always_comb begin
        if (i_cfg.pattern_kind == tppa_pkg::PATTERN_BORDER) begin
            n_hit = border;
        end else begin
            n_hit = i_cfg.stripe_enable & (par_x ^ par_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hit <= n_hit;
    end

    assign o_hit = r2_hit;

endmodule

>>> hdl/tiled_pattern_pixel_address_unit.sv
// ----------------------------------------------------------------------------
// tiled_pattern_pixel_address_unit
// pixel coordinate in, frame buffer word offset and test pattern color out
// ----------------------------------------------------------------------------
//  channel   | signals                                      | direction
//  ----------+----------------------------------------------+----------
//  pixel in  | i_start, o_busy, i_pixel_x, i_pixel_y        | in
//  result    | o_result_valid, o_word_offset, o_pixel_color | out
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data              | in
//
//  the start transfer passes through r_v1, r_v2 and r_v3 to the result strobe
//  one pixel per clock: o_busy stays low, a new coordinate can follow every cycle
//  the depth comes from the multiplier stage feeding the tile adds and the
//  afbc body add, one register level each
//  synchronous active-low reset clears the valid pipe and loads register defaults
//  results are not held: each one shows for a single cycle with o_result_valid
// ----------------------------------------------------------------------------
module tiled_pattern_pixel_address_unit #(
    parameter int COORD_BITS = tppa_pkg::DEF_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel coordinate
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [COORD_BITS-1:0]              i_pixel_x,
    input  logic [COORD_BITS-1:0]              i_pixel_y,
    // result
    output logic                               o_result_valid,
    output logic [tppa_pkg::OFFSET_BITS-1:0]   o_word_offset,
    output logic [tppa_pkg::COLOR_BITS-1:0]    o_pixel_color,
    // register writes
    input  logic                               i_cfg_we,
    input  logic [tppa_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tppa_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    tppa_pkg::t_cfg r_cfg;
    tppa_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tppa_pkg::REG_LAYOUT_MODE:   n_cfg.layout_mode   = i_cfg_data[1:0];
                tppa_pkg::REG_PATTERN_KIND:  n_cfg.pattern_kind  = i_cfg_data[0];
                tppa_pkg::REG_IMAGE_WIDTH:   n_cfg.image_width   = i_cfg_data[12:0];
                tppa_pkg::REG_IMAGE_HEIGHT:  n_cfg.image_height  = i_cfg_data[12:0];
                tppa_pkg::REG_ROW_STRIDE:    n_cfg.row_stride    = i_cfg_data[13:0];
                tppa_pkg::REG_FORE_COLOR:    n_cfg.fore_color    = i_cfg_data;
                tppa_pkg::REG_BACK_COLOR:    n_cfg.back_color    = i_cfg_data;
                tppa_pkg::REG_STRIPE_ENABLE: n_cfg.stripe_enable = i_cfg_data[0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode   <= tppa_pkg::LAYOUT_LINEAR;
            r_cfg.pattern_kind  <= tppa_pkg::PATTERN_CHECKER;
            r_cfg.image_width   <= 13'd1;
            r_cfg.image_height  <= 13'd1;
            r_cfg.row_stride    <= 14'd1;
            r_cfg.fore_color    <= '0;
            r_cfg.back_color    <= '0;
            r_cfg.stripe_enable <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ------------------------------------------------------------------
    // valid pipe, one bit per stage, never stalls
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start & ~o_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // offset pipeline, three register stages
    // ------------------------------------------------------------------
    tppa_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk         (i_clk),
        .i_cfg         (r_cfg),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_word_offset (o_word_offset)
    );

    // ------------------------------------------------------------------
    // pattern hit, two register stages, color picked in stage three
    // ------------------------------------------------------------------
    logic                            hit;
    logic [tppa_pkg::COLOR_BITS-1:0] r3_color;

    tppa_pattern #(
        .COORD_BITS (COORD_BITS)
    ) u_pattern (
        .i_clk     (i_clk),
        .i_cfg     (r_cfg),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_hit     (hit)
    );

    always_ff @(posedge i_clk) begin
        r3_color <= hit ? r_cfg.fore_color : r_cfg.back_color;
    end

    assign o_result_valid = r_v3;
    assign o_pixel_color  = r3_color;

endmodule
